@@ sv/rtt_pkg.sv @@
package rtt_pkg;

  localparam int GEN_BITS      = 26;
  localparam int SLOT_W        = 5;
  localparam int ID_W          = 8;
  localparam int TAG_W         = 32;
  localparam int TAG_GEN_SHIFT = 6;
  localparam int IN_DATA_W     = 56;
  localparam int OUT_DATA_W    = 56;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_LOOKUP  = 2'd1,
    OP_RELEASE = 2'd2,
    OP_CLOSE   = 2'd3
  } rtt_op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_CLOSED   = 2'd2,
    ST_NO_MATCH = 2'd3
  } rtt_status_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } rtt_cmd_t;

endpackage

@@ sv/rtt_ctrl.sv @@
module rtt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output rtt_pkg::rtt_cmd_t cmd
);

  typedef enum logic [1:0] {
    IDLE,
    EXEC,
    SEND
  } state_t;

  state_t state;

  assign cmd.capture = (state == IDLE) && s_axis_tvalid && s_axis_tready;
  assign cmd.execute = (state == EXEC);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      s_axis_tready <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            state         <= EXEC;
            s_axis_tready <= 1'b0;
          end else begin
            s_axis_tready <= 1'b1;
          end
        end
        EXEC: begin
          state         <= SEND;
          m_axis_tvalid <= 1'b1;
        end
        SEND: begin
          if (m_axis_tready) begin
            state         <= IDLE;
            m_axis_tvalid <= 1'b0;
            s_axis_tready <= 1'b1;
          end
        end
        default: begin
          state         <= IDLE;
          s_axis_tready <= 1'b1;
          m_axis_tvalid <= 1'b0;
        end
      endcase
    end
  end

endmodule

@@ sv/rtt_datapath.sv @@
module rtt_datapath #(
  parameter int NUM_SLOTS = 32,
  parameter int ID_BITS   = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  rtt_pkg::rtt_cmd_t                  cmd,
  input  logic [rtt_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  input  logic [1:0]                         s_axis_tuser,
  output logic [rtt_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic [1:0]                         m_axis_tuser
);

  localparam int SLOT_BITS = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int KEEP_BITS = (ID_BITS < rtt_pkg::ID_W) ? ID_BITS : rtt_pkg::ID_W;
  localparam int GB        = rtt_pkg::GEN_BITS;
  localparam int SW        = rtt_pkg::SLOT_W;

  rtt_pkg::rtt_op_t     op;
  logic [rtt_pkg::ID_W-1:0]  cid;
  logic [SW-1:0]             cslot;
  logic [rtt_pkg::TAG_W-1:0] serial;
  logic [SW-1:0]             sidx;

  logic [NUM_SLOTS-1:0] free_map;
  logic                 closed;
  logic [GB-1:0]        gen       [NUM_SLOTS];
  logic [KEEP_BITS-1:0] owner_id  [NUM_SLOTS];
  logic [SW-1:0]        owner_slot[NUM_SLOTS];

  rtt_pkg::rtt_status_t      status;
  logic [SW-1:0]             slot;
  logic [rtt_pkg::TAG_W-1:0] tag;
  logic [rtt_pkg::ID_W-1:0]  mid;
  logic [SW-1:0]             mslot;

  rtt_pkg::rtt_status_t      status_next;
  logic [SW-1:0]             slot_next;
  logic [rtt_pkg::TAG_W-1:0] tag_next;
  logic [rtt_pkg::ID_W-1:0]  mid_next;
  logic [SW-1:0]             mslot_next;

  logic [SLOT_BITS-1:0] alloc_idx;
  logic                 any_free;
  logic [GB-1:0]        gen_inc;
  logic [SW-1:0]        lk_slot;
  logic [SLOT_BITS-1:0] lk_idx;
  logic                 lk_hit;
  logic [SLOT_BITS-1:0] rel_idx;
  logic                 rel_ok;
  logic                 do_alloc;
  logic                 do_free;
  logic [SLOT_BITS-1:0] free_idx;
  logic                 do_close;

  always_comb begin
    alloc_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (free_map[i]) begin
        alloc_idx = SLOT_BITS'(i);
      end
    end
  end

  assign any_free = |free_map;
  assign gen_inc  = gen[alloc_idx] + GB'(1);

  assign lk_slot = serial[SW:1];
  assign lk_idx  = lk_slot[SLOT_BITS-1:0];
  assign lk_hit  = serial[0] && ({1'b0, lk_slot} < (SW + 1)'(NUM_SLOTS)) &&
                   !free_map[lk_idx] &&
                   (serial[rtt_pkg::TAG_W-1:rtt_pkg::TAG_GEN_SHIFT] == gen[lk_idx]);

  assign rel_idx = sidx[SLOT_BITS-1:0];
  assign rel_ok  = ({1'b0, sidx} < (SW + 1)'(NUM_SLOTS));

  always_comb begin
    status_next = rtt_pkg::ST_OK;
    slot_next   = '0;
    tag_next    = '0;
    mid_next    = '0;
    mslot_next  = '0;
    do_alloc    = 1'b0;
    do_free     = 1'b0;
    free_idx    = rel_idx;
    do_close    = 1'b0;
    case (op)
      rtt_pkg::OP_ALLOC: begin
        if (closed) begin
          status_next = rtt_pkg::ST_CLOSED;
        end else if (!any_free) begin
          status_next = rtt_pkg::ST_FULL;
        end else begin
          do_alloc  = 1'b1;
          slot_next = SW'(alloc_idx);
          tag_next  = {gen_inc, SW'(alloc_idx), 1'b1};
        end
      end
      rtt_pkg::OP_LOOKUP: begin
        free_idx = lk_idx;
        if (lk_hit) begin
          do_free    = 1'b1;
          slot_next  = lk_slot;
          mid_next   = rtt_pkg::ID_W'(owner_id[lk_idx]);
          mslot_next = owner_slot[lk_idx];
        end else begin
          status_next = rtt_pkg::ST_NO_MATCH;
        end
      end
      rtt_pkg::OP_RELEASE: begin
        if (rel_ok) begin
          do_free   = 1'b1;
          slot_next = sidx;
        end else begin
          status_next = rtt_pkg::ST_NO_MATCH;
        end
      end
      rtt_pkg::OP_CLOSE: begin
        do_close = 1'b1;
      end
      default: begin
        status_next = rtt_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op     <= rtt_pkg::rtt_op_t'(s_axis_tuser);
      cid    <= s_axis_tdata[7:0];
      cslot  <= s_axis_tdata[12:8];
      serial <= s_axis_tdata[44:13];
      sidx   <= s_axis_tdata[49:45];
    end
    if (cmd.execute) begin
      status <= status_next;
      slot   <= slot_next;
      tag    <= tag_next;
      mid    <= mid_next;
      mslot  <= mslot_next;
      if (do_alloc) begin
        owner_id[alloc_idx]   <= cid[KEEP_BITS-1:0];
        owner_slot[alloc_idx] <= cslot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_map <= '1;
      closed   <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        gen[i] <= '0;
      end
    end else if (cmd.execute) begin
      if (do_alloc) begin
        free_map[alloc_idx] <= 1'b0;
        gen[alloc_idx]      <= gen_inc;
      end
      if (do_free) begin
        free_map[free_idx] <= 1'b1;
      end
      if (do_close) begin
        closed <= 1'b1;
      end
    end
  end

  assign m_axis_tuser = status;
  assign m_axis_tdata = {6'd0, mslot, mid, tag, slot};

endmodule

@@ sv/request_tag_table_top.sv @@
// Tag table for outstanding requests. Each slave transaction carries one
// operation in tuser (allocate, reply lookup, release, close) and yields
// exactly one master transaction with the status in tuser. The operation
// executes in the clock after the slave transaction is accepted and its result
// is presented from the next clock on. The result holds until m_axis_tready.
// The next slave transaction can be accepted in the clock after the master
// transaction; no new operation is accepted before the last result is taken.
// Allocate picks the lowest free slot and returns gen<<6 | slot<<1 | 1.
module request_tag_table_top #(
  parameter int NUM_SLOTS = 32,
  parameter int ID_BITS   = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // client_id[7:0], client_slot[12:8], reply_tag[44:13], slot_index[49:45]
  input  logic [55:0] s_axis_tdata,
  // operation[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // slot[4:0], tag[36:5], match_client_id[44:37], match_client_slot[49:45]
  output logic [55:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]  m_axis_tuser
);

  rtt_pkg::rtt_cmd_t cmd;

  rtt_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd           (cmd)
  );

  rtt_datapath #(
    .NUM_SLOTS (NUM_SLOTS),
    .ID_BITS   (ID_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

endmodule
